[rtl/lu_pkg.sv]
`default_nettype none
package lu_pkg;

    localparam int MATRIX_ORDER = 16;
    localparam int FRAC_BITS    = 16;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = $clog2(MATRIX_ORDER);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ADDR_W       = 2 * IDX_W;
    localparam int DEPTH        = MATRIX_ORDER * MATRIX_ORDER;
    localparam int DVD_W        = DATA_W + FRAC_BITS;
    localparam int DCNT_W       = $clog2(DVD_W);
    localparam int PROD_W       = 2 * DATA_W;

    // item function codes
    localparam logic [1:0] FN_LOAD_A = 2'd0;
    localparam logic [1:0] FN_LOAD_B = 2'd1;
    localparam logic [1:0] FN_SOLVE  = 2'd2;

    // solve status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PIVOT = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] val;
    } t_sat_val;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

    // clamp a wide signed value to the data range
    function automatic t_sat_val clamp_w(input logic signed [PROD_W:0] v);
        t_sat_val r;
        r.sat = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > $signed({{(PROD_W-DATA_W+1){1'b0}}, SAT_MAX})) begin
            r.sat = 1'b1;
            r.val = SAT_MAX;
        end else if (v < $signed({{(PROD_W-DATA_W+1){1'b1}}, SAT_MIN})) begin
            r.sat = 1'b1;
            r.val = SAT_MIN;
        end
        return r;
    endfunction

    // product rounded to nearest, ties up, then clamped
    function automatic t_sat_val rnd_clamp(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] s;
        s = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(1) << (FRAC_BITS - 1));
        return clamp_w(s >>> FRAC_BITS);
    endfunction

    function automatic t_sat_val sat_add(input logic signed [DATA_W-1:0] a,
                                         input logic signed [DATA_W-1:0] b);
        logic signed [PROD_W:0] s;
        s = (PROD_W+1)'(a) + (PROD_W+1)'(b);
        return clamp_w(s);
    endfunction

    function automatic t_sat_val sat_sub(input logic signed [DATA_W-1:0] a,
                                         input logic signed [DATA_W-1:0] b);
        logic signed [PROD_W:0] s;
        s = (PROD_W+1)'(a) - (PROD_W+1)'(b);
        return clamp_w(s);
    endfunction

endpackage
`default_nettype wire

[rtl/lu_ram.sv]
`default_nettype none
module lu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

[rtl/lu_cell.sv]
`default_nettype none
module lu_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_shift,
    input  wire logic signed [lu_pkg::DATA_W-1:0] i_data,
    output logic signed      [lu_pkg::DATA_W-1:0] o_data
);

    logic signed [lu_pkg::DATA_W-1:0] r_val;

    // take the neighbor's value on each shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_data;
        end
    end

    assign o_data = r_val;

endmodule
`default_nettype wire

[rtl/lu_div.sv]
`default_nettype none
module lu_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic signed [lu_pkg::DATA_W-1:0] i_num,
    input  wire logic signed [lu_pkg::DATA_W-1:0] i_den,
    output lu_pkg::t_div_stat                     o_stat,
    output logic signed      [lu_pkg::DATA_W-1:0] o_quot
);

    logic [lu_pkg::DVD_W-1:0]  r_dvd;
    logic [lu_pkg::DATA_W-1:0] r_dsr;
    logic [lu_pkg::DATA_W-1:0] r_rem;
    logic [lu_pkg::DCNT_W-1:0] r_cnt;
    logic                      r_neg;
    logic                      r_busy;
    logic                      r_done;

    logic signed [lu_pkg::DVD_W-1:0] num_s;
    logic [lu_pkg::DVD_W-1:0]        an;
    logic [lu_pkg::DATA_W-1:0]       ad;
    logic [lu_pkg::DATA_W:0]         rem_sh;
    logic                            q_bit;
    logic [lu_pkg::DVD_W-1:0]        q_lim;
    lu_pkg::t_sat_val                res;

    // magnitudes with half the divisor added for rounding
    always_comb begin
        num_s  = lu_pkg::DVD_W'(i_num) <<< lu_pkg::FRAC_BITS;
        an     = num_s[lu_pkg::DVD_W-1] ? lu_pkg::DVD_W'(-num_s) : lu_pkg::DVD_W'(num_s);
        ad     = i_den[lu_pkg::DATA_W-1] ? lu_pkg::DATA_W'(-i_den)
                                         : lu_pkg::DATA_W'(i_den);
        rem_sh = {r_rem, r_dvd[lu_pkg::DVD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dsr});
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= an + lu_pkg::DVD_W'(ad >> 1);
                r_dsr  <= ad;
                r_rem  <= '0;
                r_neg  <= i_num[lu_pkg::DATA_W-1] ^ i_den[lu_pkg::DATA_W-1];
            end else if (r_busy) begin
                r_rem <= q_bit ? lu_pkg::DATA_W'(rem_sh - {1'b0, r_dsr})
                               : rem_sh[lu_pkg::DATA_W-1:0];
                r_dvd <= {r_dvd[lu_pkg::DVD_W-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lu_pkg::DCNT_W'(lu_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // signed quotient clamp
    always_comb begin
        q_lim   = lu_pkg::DVD_W'(1) << (lu_pkg::DATA_W - 1);
        res.sat = 1'b0;
        res.val = r_neg ? lu_pkg::DATA_W'(-r_dvd) : r_dvd[lu_pkg::DATA_W-1:0];
        if (r_neg && (r_dvd > q_lim)) begin
            res.sat = 1'b1;
            res.val = lu_pkg::SAT_MIN;
        end else if (!r_neg && (r_dvd >= q_lim)) begin
            res.sat = 1'b1;
            res.val = lu_pkg::SAT_MAX;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.sat  = res.sat;
    assign o_quot      = res.val;

endmodule
`default_nettype wire

[rtl/lu_decompose_solve_core.sv]
`default_nettype none
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+------------------------------------
// command   | in        | i_start, o_busy          | i_func, i_row_index, i_col_index,
//           |           |                          | i_entry_value
// result    | out       | o_solution_valid (strobe)| o_solution_index, o_solution_value,
//           |           |                          | o_last_entry, o_solve_status
// config    | in        | i_cfg_wr_en              | i_cfg_wr_data (order in use)
//
// loads never raise busy
// a solve of order n runs in steps: each term costs a read, a multiply, a round
// and an update, each pivot row is read from memory into the cell chain, and the
// quotients come from the bit-serial divider
// results then come out one per cycle, n in all
// synchronous active-low reset; the matrix memories are not cleared
// results cannot be stalled: each strobe lasts exactly one cycle
module lu_decompose_solve_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [1:0]                       i_func,
    input  wire logic [3:0]                       i_row_index,
    input  wire logic [3:0]                       i_col_index,
    input  wire logic signed [lu_pkg::DATA_W-1:0] i_entry_value,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [4:0]                       i_cfg_wr_data,
    output logic                                  o_solution_valid,
    output logic [3:0]                            o_solution_index,
    output logic signed [lu_pkg::DATA_W-1:0]      o_solution_value,
    output logic                                  o_last_entry,
    output logic [1:0]                            o_solve_status
);

    localparam int N  = lu_pkg::MATRIX_ORDER;
    localparam int IW = lu_pkg::IDX_W;
    localparam int CW = lu_pkg::CNT_W;
    localparam int DW = lu_pkg::DATA_W;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_PIV_RD = 5'd1;
    localparam logic [4:0] S_PIV_CK = 5'd2;
    localparam logic [4:0] S_LD_RD  = 5'd3;
    localparam logic [4:0] S_LD_SH  = 5'd4;
    localparam logic [4:0] S_L_RD   = 5'd5;
    localparam logic [4:0] S_L_DIV  = 5'd6;
    localparam logic [4:0] S_L_WAIT = 5'd7;
    localparam logic [4:0] S_K_RD   = 5'd8;
    localparam logic [4:0] S_K_MUL  = 5'd9;
    localparam logic [4:0] S_K_RND  = 5'd10;
    localparam logic [4:0] S_K_SUB  = 5'd11;
    localparam logic [4:0] S_F_ROW  = 5'd12;
    localparam logic [4:0] S_F_RD   = 5'd13;
    localparam logic [4:0] S_F_MUL  = 5'd14;
    localparam logic [4:0] S_F_RND  = 5'd15;
    localparam logic [4:0] S_F_ACC  = 5'd16;
    localparam logic [4:0] S_B_ROW  = 5'd17;
    localparam logic [4:0] S_B_RD   = 5'd18;
    localparam logic [4:0] S_B_MUL  = 5'd19;
    localparam logic [4:0] S_B_RND  = 5'd20;
    localparam logic [4:0] S_B_ACC  = 5'd21;
    localparam logic [4:0] S_B_DIV  = 5'd22;
    localparam logic [4:0] S_B_WAIT = 5'd23;
    localparam logic [4:0] S_OUT    = 5'd24;

    logic [4:0]    r_state;
    logic [4:0]    r_order;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_k;
    logic          r_sat;
    logic          r_fail;

    logic signed [DW-1:0] r_piv;
    logic signed [DW-1:0] r_l;
    logic signed [DW-1:0] r_t;
    logic signed [DW-1:0] r_acc;
    logic signed [lu_pkg::PROD_W-1:0] r_prod;
    logic signed [DW-1:0] r_y [N];
    logic signed [DW-1:0] r_x [N];
    logic signed [DW-1:0] r_b [N];

    logic [CW-1:0] n_use;
    logic          accept;
    logic          k_live;
    logic          k_last;
    logic          chain_shift;

    logic                      u_we;
    logic [lu_pkg::ADDR_W-1:0] u_waddr;
    logic signed [DW-1:0]      u_wdata;
    logic                      u_re;
    logic [lu_pkg::ADDR_W-1:0] u_raddr;
    logic signed [DW-1:0]      u_rd;
    logic                      l_we;
    logic                      l_re;
    logic signed [DW-1:0]      l_rd;

    logic signed [DW-1:0] cell_q [N];
    logic signed [DW-1:0] head;
    logic signed [DW-1:0] chain_in;

    logic signed [DW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic signed [DW-1:0] y_rd;
    logic [IW-1:0]        y_addr;
    logic signed [DW-1:0] x_rd;

    lu_pkg::t_sat_val rnd;
    lu_pkg::t_sat_val acc_sum;
    lu_pkg::t_sat_val k_diff;
    lu_pkg::t_sat_val f_diff;
    lu_pkg::t_sat_val b_diff;

    logic                 div_start;
    logic signed [DW-1:0] div_num;
    logic signed [DW-1:0] div_den;
    lu_pkg::t_div_stat    div_stat;
    logic signed [DW-1:0] div_q;

    // order in use, clamped to the supported range
    always_comb begin
        if (r_order < 5'd2) begin
            n_use = CW'(2);
        end else if (r_order > 5'(N)) begin
            n_use = CW'(N);
        end else begin
            n_use = CW'(r_order);
        end
    end

    assign accept = i_start && !o_busy;
    assign k_live = (r_k > r_j) && (r_k < r_n);
    assign k_last = (r_k == CW'(N - 1));

    // shared datapath operands
    assign head   = cell_q[0];
    assign y_addr = (r_state == S_F_MUL) ? r_i[IW-1:0] : r_j[IW-1:0];
    assign y_rd   = r_y[y_addr];
    assign x_rd   = r_x[r_i[IW-1:0]];

    always_comb begin
        unique case (r_state)
            S_F_MUL: begin
                mul_a = y_rd;
                mul_b = l_rd;
            end
            S_B_MUL: begin
                mul_a = x_rd;
                mul_b = u_rd;
            end
            default: begin
                mul_a = r_l;
                mul_b = head;
            end
        endcase
    end

    assign rnd     = lu_pkg::rnd_clamp(r_prod);
    assign acc_sum = lu_pkg::sat_add(r_acc, r_t);
    assign k_diff  = lu_pkg::sat_sub(u_rd, r_t);
    assign f_diff  = lu_pkg::sat_sub(r_b[r_j[IW-1:0]], r_acc);
    assign b_diff  = lu_pkg::sat_sub(y_rd, r_acc);

    // matrix memory ports
    always_comb begin
        u_we    = 1'b0;
        u_waddr = {r_i[IW-1:0], r_k[IW-1:0]};
        u_wdata = k_diff.val;
        u_re    = 1'b0;
        u_raddr = {r_i[IW-1:0], r_k[IW-1:0]};
        unique case (r_state)
            S_IDLE: begin
                u_we    = accept && (i_func == lu_pkg::FN_LOAD_A);
                u_waddr = {i_row_index, i_col_index};
                u_wdata = i_entry_value;
            end
            S_PIV_RD: begin
                u_re    = 1'b1;
                u_raddr = {r_j[IW-1:0], r_j[IW-1:0]};
            end
            S_LD_RD: begin
                u_re    = 1'b1;
                u_raddr = {r_j[IW-1:0], r_k[IW-1:0]};
            end
            S_L_RD: begin
                u_re    = 1'b1;
                u_raddr = {r_i[IW-1:0], r_j[IW-1:0]};
            end
            S_L_DIV: begin
                u_we    = 1'b1;
                u_waddr = {r_i[IW-1:0], r_j[IW-1:0]};
                u_wdata = '0;
            end
            S_K_RD: begin
                u_re = k_live;
            end
            S_K_SUB: begin
                u_we = 1'b1;
            end
            S_B_RD: begin
                u_re    = 1'b1;
                u_raddr = (r_i == r_n) ? {r_j[IW-1:0], r_j[IW-1:0]}
                                       : {r_j[IW-1:0], r_i[IW-1:0]};
            end
            default: begin
                u_re = 1'b0;
            end
        endcase
    end

    assign l_we = (r_state == S_L_WAIT) && div_stat.done;
    assign l_re = (r_state == S_F_RD) && (r_i != r_j);

    lu_ram #(.WIDTH(DW), .DEPTH(lu_pkg::DEPTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_re    (u_re),
        .i_raddr (u_raddr),
        .o_rdata (u_rd)
    );

    lu_ram #(.WIDTH(DW), .DEPTH(lu_pkg::DEPTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr ({r_i[IW-1:0], r_j[IW-1:0]}),
        .i_wdata (div_q),
        .i_re    (l_re),
        .i_raddr ({r_j[IW-1:0], r_i[IW-1:0]}),
        .o_rdata (l_rd)
    );

    // pivot row chain: filled from memory, then rotated one column per step
    assign chain_shift = (r_state == S_LD_SH) || (r_state == S_K_SUB)
                       || ((r_state == S_K_RD) && !k_live);
    assign chain_in    = (r_state == S_LD_SH) ? u_rd : head;

    for (genvar c = 0; c < N; c++) begin : g_chain
        lu_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (chain_shift),
            .i_data  ((c == N - 1) ? chain_in : cell_q[(c + 1) % N]),
            .o_data  (cell_q[c])
        );
    end

    // divider shared by the multipliers of L and the back substitution
    assign div_start = (r_state == S_L_DIV) || (r_state == S_B_DIV);
    assign div_num   = (r_state == S_L_DIV) ? u_rd : r_t;
    assign div_den   = (r_state == S_L_DIV) ? r_piv : u_rd;

    lu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_q)
    );

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 5'd16;
        end else if (i_cfg_wr_en) begin
            r_order <= i_cfg_wr_data;
        end
    end

    // right-hand loads
    always_ff @(posedge i_clk) begin
        if (accept && (i_func == lu_pkg::FN_LOAD_B)) begin
            r_b[i_row_index] <= i_entry_value;
        end
    end

    // solve sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_n     <= CW'(2);
            r_sat   <= 1'b0;
            r_fail  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_func == lu_pkg::FN_SOLVE)) begin
                        r_n     <= n_use;
                        r_j     <= '0;
                        r_sat   <= 1'b0;
                        r_fail  <= 1'b0;
                        r_state <= S_PIV_RD;
                    end
                end
                S_PIV_RD: r_state <= S_PIV_CK;
                S_PIV_CK: begin
                    r_piv <= u_rd;
                    r_k   <= '0;
                    if (u_rd == '0) begin
                        r_fail  <= 1'b1;
                        r_i     <= '0;
                        r_state <= S_OUT;
                    end else if (r_j == r_n - 1'b1) begin
                        r_j     <= '0;
                        r_state <= S_F_ROW;
                    end else begin
                        r_state <= S_LD_RD;
                    end
                end
                S_LD_RD: r_state <= S_LD_SH;
                S_LD_SH: begin
                    if (k_last) begin
                        r_i     <= r_j + 1'b1;
                        r_state <= S_L_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_LD_RD;
                    end
                end
                S_L_RD:  r_state <= S_L_DIV;
                S_L_DIV: r_state <= S_L_WAIT;
                S_L_WAIT: begin
                    if (div_stat.done) begin
                        r_l     <= div_q;
                        r_sat   <= r_sat | div_stat.sat;
                        r_k     <= '0;
                        r_state <= S_K_RD;
                    end
                end
                S_K_RD: begin
                    if (k_live) begin
                        r_state <= S_K_MUL;
                    end else if (k_last) begin
                        if (r_i == r_n - 1'b1) begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_PIV_RD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_L_RD;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_K_MUL: r_state <= S_K_RND;
                S_K_RND: begin
                    r_t     <= rnd.val;
                    r_sat   <= r_sat | rnd.sat;
                    r_state <= S_K_SUB;
                end
                S_K_SUB: begin
                    r_sat <= r_sat | k_diff.sat;
                    if (k_last) begin
                        if (r_i == r_n - 1'b1) begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_PIV_RD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_L_RD;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_K_RD;
                    end
                end
                // forward substitution
                S_F_ROW: begin
                    r_acc <= '0;
                    r_i   <= '0;
                    if (r_j == r_n) begin
                        r_j     <= r_n - 1'b1;
                        r_state <= S_B_ROW;
                    end else begin
                        r_state <= S_F_RD;
                    end
                end
                S_F_RD: begin
                    if (r_i == r_j) begin
                        r_y[r_j[IW-1:0]] <= f_diff.val;
                        r_sat            <= r_sat | f_diff.sat;
                        r_j              <= r_j + 1'b1;
                        r_state          <= S_F_ROW;
                    end else begin
                        r_state <= S_F_MUL;
                    end
                end
                S_F_MUL: r_state <= S_F_RND;
                S_F_RND: begin
                    r_t     <= rnd.val;
                    r_sat   <= r_sat | rnd.sat;
                    r_state <= S_F_ACC;
                end
                S_F_ACC: begin
                    r_acc   <= acc_sum.val;
                    r_sat   <= r_sat | acc_sum.sat;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_F_RD;
                end
                // back substitution
                S_B_ROW: begin
                    r_acc   <= '0;
                    r_i     <= r_j + 1'b1;
                    r_state <= S_B_RD;
                end
                S_B_RD: begin
                    if (r_i == r_n) begin
                        r_t     <= b_diff.val;
                        r_sat   <= r_sat | b_diff.sat;
                        r_state <= S_B_DIV;
                    end else begin
                        r_state <= S_B_MUL;
                    end
                end
                S_B_MUL: r_state <= S_B_RND;
                S_B_RND: begin
                    r_t     <= rnd.val;
                    r_sat   <= r_sat | rnd.sat;
                    r_state <= S_B_ACC;
                end
                S_B_ACC: begin
                    r_acc   <= acc_sum.val;
                    r_sat   <= r_sat | acc_sum.sat;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_B_RD;
                end
                S_B_DIV: r_state <= S_B_WAIT;
                S_B_WAIT: begin
                    if (div_stat.done) begin
                        r_x[r_j[IW-1:0]] <= div_q;
                        r_sat            <= r_sat | div_stat.sat;
                        if (r_j == '0) begin
                            r_i     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_j     <= r_j - 1'b1;
                            r_state <= S_B_ROW;
                        end
                    end
                end
                // one solution transfer per cycle
                S_OUT: begin
                    if (r_i == r_n - 1'b1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result port
    assign o_busy           = (r_state != S_IDLE);
    assign o_solution_valid = (r_state == S_OUT);
    assign o_solution_index = r_i[IW-1:0];
    assign o_solution_value = r_fail ? '0 : x_rd;
    assign o_last_entry     = o_solution_valid && (r_i == r_n - 1'b1);
    assign o_solve_status   = r_fail ? lu_pkg::ST_PIVOT
                            : (r_sat ? lu_pkg::ST_SAT : lu_pkg::ST_OK);

    // a pivot failure always reports zero values
    a_pivot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_solution_valid && (o_solve_status == lu_pkg::ST_PIVOT))
            |-> (o_solution_value == '0))
        else $error("pivot failure with nonzero value");

    // the final transfer ends the solve
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_entry |=> !o_busy)
        else $error("busy after last transfer");

    // transfers run in index order
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_solution_valid && !o_last_entry)
            |=> (o_solution_valid
                 && (o_solution_index == $past(o_solution_index) + 1'b1)))
        else $error("solution index out of order");

endmodule
`default_nettype wire
